>>> rtl/s20h_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s20h_pkg: shared types and helpers for the Salsa20 core hash
// Word and state types, item structs, pipeline record and quarter-step
// indexing and rotation helpers.
// ----------------------------------------------------------------------------
package s20h_pkg;

	localparam int DOUBLE_ROUNDS = 10;
	localparam int NUM_WORDS     = 16;
	// Four dependent quarter-steps per round, two rounds per double round
	localparam int NUM_STEPS     = DOUBLE_ROUNDS * 8;
	localparam int LATENCY       = NUM_STEPS + 1;

	typedef logic [31:0] word_t;
	typedef logic [NUM_WORDS-1:0][31:0] state_t;

	typedef struct packed {
		logic [63:0] in_words_0_1;
		logic [63:0] in_words_2_3;
		logic [63:0] in_words_4_5;
		logic [63:0] in_words_6_7;
		logic [63:0] in_words_8_9;
		logic [63:0] in_words_10_11;
		logic [63:0] in_words_12_13;
		logic [63:0] in_words_14_15;
	} in_t;

	typedef struct packed {
		logic [63:0] out_words_0_1;
		logic [63:0] out_words_2_3;
		logic [63:0] out_words_4_5;
		logic [63:0] out_words_6_7;
		logic [63:0] out_words_8_9;
		logic [63:0] out_words_10_11;
		logic [63:0] out_words_12_13;
		logic [63:0] out_words_14_15;
	} out_t;

	// Quarter-step code: names the word that the step updates
	typedef enum logic [1:0] {
		STEP_B = 2'd0,
		STEP_C = 2'd1,
		STEP_D = 2'd2,
		STEP_A = 2'd3
	} step_e;

	typedef struct packed {
		logic  row;
		step_e step;
	} step_ctl_t;

	typedef struct packed {
		logic   valid;
		state_t y;
		state_t orig;
	} pipe_t;

	// Word index of position pos (a=0..d=3) in quarter-round qr
	function automatic logic [3:0] word_idx(input logic row, input logic [1:0] qr,
			input logic [1:0] pos);
		logic [1:0] k;
		k = qr + pos;
		return row ? {qr, k} : {k, qr};
	endfunction

	function automatic word_t rot_step(input step_e step, input word_t v);
		word_t r;
		case (step)
			STEP_B: r = {v[24:0], v[31:25]};
			STEP_C: r = {v[22:0], v[31:23]};
			STEP_D: r = {v[18:0], v[31:19]};
			STEP_A: r = {v[13:0], v[31:14]};
			default: r = v;
		endcase
		return r;
	endfunction

	function automatic state_t unpack_in(input in_t d);
		state_t y;
		y[0]  = d.in_words_0_1[31:0];
		y[1]  = d.in_words_0_1[63:32];
		y[2]  = d.in_words_2_3[31:0];
		y[3]  = d.in_words_2_3[63:32];
		y[4]  = d.in_words_4_5[31:0];
		y[5]  = d.in_words_4_5[63:32];
		y[6]  = d.in_words_6_7[31:0];
		y[7]  = d.in_words_6_7[63:32];
		y[8]  = d.in_words_8_9[31:0];
		y[9]  = d.in_words_8_9[63:32];
		y[10] = d.in_words_10_11[31:0];
		y[11] = d.in_words_10_11[63:32];
		y[12] = d.in_words_12_13[31:0];
		y[13] = d.in_words_12_13[63:32];
		y[14] = d.in_words_14_15[31:0];
		y[15] = d.in_words_14_15[63:32];
		return y;
	endfunction

	function automatic out_t pack_out(input state_t y);
		out_t o;
		o.out_words_0_1   = {y[1], y[0]};
		o.out_words_2_3   = {y[3], y[2]};
		o.out_words_4_5   = {y[5], y[4]};
		o.out_words_6_7   = {y[7], y[6]};
		o.out_words_8_9   = {y[9], y[8]};
		o.out_words_10_11 = {y[11], y[10]};
		o.out_words_12_13 = {y[13], y[12]};
		o.out_words_14_15 = {y[15], y[14]};
		return o;
	endfunction

endpackage
`default_nettype wire

>>> rtl/s20h_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s20h_step: one quarter-step pipeline stage
// Runs the same add-rotate-xor step of all four quarter-rounds of a column
// or row round in parallel and registers the state.
// ----------------------------------------------------------------------------
module s20h_step (
	input  logic                  clk,
	input  logic                  arst_n,
	input  s20h_pkg::step_ctl_t   ctl,
	input  s20h_pkg::pipe_t       d,
	output s20h_pkg::pipe_t       q
);

	logic [1:0]       pos_t;
	logic [1:0]       pos_s;
	logic [1:0]       pos_r;
	s20h_pkg::state_t y_nxt;
	logic             valid_s1;
	s20h_pkg::state_t y_s1;
	s20h_pkg::state_t orig_s1;

	// Target word follows the step; its two sources are the two positions before it
	assign pos_t = 2'(ctl.step) + 2'd1;
	assign pos_s = 2'(ctl.step);
	assign pos_r = 2'(ctl.step) - 2'd1;

	always_comb begin
		y_nxt = d.y;
		for (int qr = 0; qr < 4; qr++) begin
			y_nxt[s20h_pkg::word_idx(ctl.row, 2'(qr), pos_t)] =
				d.y[s20h_pkg::word_idx(ctl.row, 2'(qr), pos_t)] ^
				s20h_pkg::rot_step(ctl.step,
					d.y[s20h_pkg::word_idx(ctl.row, 2'(qr), pos_s)] +
					d.y[s20h_pkg::word_idx(ctl.row, 2'(qr), pos_r)]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		y_s1    <= y_nxt;
		orig_s1 <= d.orig;
	end

	assign q.valid = valid_s1;
	assign q.y     = y_s1;
	assign q.orig  = orig_s1;

endmodule
`default_nettype wire

>>> rtl/s20h_final.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// s20h_final: feed-forward add stage
// Adds the original input words to the mixed state and registers the result.
// ----------------------------------------------------------------------------
module s20h_final (
	input  logic              clk,
	input  logic              arst_n,
	input  s20h_pkg::pipe_t   d,
	output logic              done,
	output s20h_pkg::out_t    result
);

	logic             done_s1;
	s20h_pkg::state_t sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < s20h_pkg::NUM_WORDS; i++) begin
			sum_s1[i] <= d.y[i] + d.orig[i];
		end
	end

	assign done   = done_s1;
	assign result = s20h_pkg::pack_out(sum_s1);

endmodule
`default_nettype wire

>>> rtl/salsa20_core_hash.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salsa20_core_hash: Salsa20 core hash, fully pipelined
// Mixes one 512-bit state through the double rounds and adds the input back.
// ----------------------------------------------------------------------------
// An item is taken in every cycle that start is high; busy stays low, since
// nothing downstream can stall the pipeline. Each item leaves the pipeline
// after passing through every stage, with done
// high for one cycle and the result on the result port in that same cycle.
// The depth comes from one register stage per quarter-step (four per round,
// all four quarter-rounds side by side) plus one stage for the final add.
// Results come out in the order the items went in.
// ----------------------------------------------------------------------------
module salsa20_core_hash (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  s20h_pkg::in_t     data,
	output logic              done,
	output s20h_pkg::out_t    result
);

	s20h_pkg::pipe_t pipe [0:s20h_pkg::NUM_STEPS];

	assign busy = 1'b0;

	assign pipe[0].valid = start && !busy;
	assign pipe[0].y     = s20h_pkg::unpack_in(data);
	assign pipe[0].orig  = s20h_pkg::unpack_in(data);

	// Even rounds work on columns, odd rounds on rows
	for (genvar g = 0; g < s20h_pkg::NUM_STEPS; g++) begin : g_step
		s20h_pkg::step_ctl_t ctl;

		assign ctl.row  = 1'((g >> 2) & 1);
		assign ctl.step = s20h_pkg::step_e'(2'(g));

		s20h_step u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.d      (pipe[g]),
			.q      (pipe[g+1])
		);
	end

	s20h_final u_final (
		.clk    (clk),
		.arst_n (arst_n),
		.d      (pipe[s20h_pkg::NUM_STEPS]),
		.done   (done),
		.result (result)
	);

	// Every accepted item comes out after the fixed latency
	a_item_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(s20h_pkg::LATENCY) done)
		else $error("accepted item did not come out after the pipeline latency");

	// No result without an item accepted the pipeline latency earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, s20h_pkg::LATENCY))
		else $error("result strobe without a matching accepted item");

	// Valid bit halfway down the steps must match an item accepted at the input
	a_mid_valid: assert property (@(posedge clk) disable iff (!arst_n)
		pipe[s20h_pkg::NUM_STEPS/2].valid |->
			$past(start && !busy, s20h_pkg::NUM_STEPS/2))
		else $error("mid-pipeline valid bit out of step with accepted items");

endmodule
`default_nettype wire

>>> sim/tb_salsa20_core_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_salsa20_core_hash: self-checking bench for the Salsa20 core hash
// Feeds directed edge patterns and random 512-bit blocks through the start
// handshake with random gaps and back-to-back bursts. Each taken block is
// hashed by a behavioral Salsa20 model in the bench, and each done strobe is
// compared field by field with the oldest pending hash.
// ----------------------------------------------------------------------------
module tb_salsa20_core_hash;

	localparam int NUM_RANDOM   = 750;
	localparam int SETTLE       = s20h_pkg::LATENCY + 20;
	localparam int MAX_REPORTED = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	s20h_pkg::in_t  data = '0;
	logic done;
	s20h_pkg::out_t result;

	s20h_pkg::in_t  pending_blocks[$];
	s20h_pkg::out_t expected_hashes[$];

	bit  took = 1'b0;
	bit  burst = 1'b0;
	int  idle_left = 0;
	int  mismatches = 0;
	s20h_pkg::out_t want;
	logic [7:0][63:0] want_f;
	logic [7:0][63:0] got_f;

	salsa20_core_hash uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.data   (data),
		.done   (done),
		.result (result)
	);

	always #10 clk = ~clk;

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	// Full Salsa20 core: double rounds, then add the input words back
	function automatic s20h_pkg::out_t salsa_hash(input s20h_pkg::in_t blk);
		logic [7:0][63:0] fin;
		logic [7:0][63:0] fout;
		logic [31:0] orig [16];
		logic [31:0] y [16];
		int a, b, c, d;
		fin = blk;
		for (int i = 0; i < 8; i++) begin
			orig[2*i]   = fin[7-i][31:0];
			orig[2*i+1] = fin[7-i][63:32];
		end
		for (int i = 0; i < 16; i++)
			y[i] = orig[i];
		for (int r = 0; r < s20h_pkg::DOUBLE_ROUNDS; r++) begin
			for (int pass = 0; pass < 2; pass++) begin
				for (int q = 0; q < 4; q++) begin
					// column pass walks down a column, row pass along a row
					a = 5 * q;
					b = pass ? q*4 + (q+1)%4 : ((q+1)%4)*4 + q;
					c = pass ? q*4 + (q+2)%4 : ((q+2)%4)*4 + q;
					d = pass ? q*4 + (q+3)%4 : ((q+3)%4)*4 + q;
					y[b] = y[b] ^ rotl32(y[a] + y[d], 7);
					y[c] = y[c] ^ rotl32(y[b] + y[a], 9);
					y[d] = y[d] ^ rotl32(y[c] + y[b], 13);
					y[a] = y[a] ^ rotl32(y[d] + y[c], 18);
				end
			end
		end
		for (int i = 0; i < 8; i++)
			fout[7-i] = {y[2*i+1] + orig[2*i+1], y[2*i] + orig[2*i]};
		return s20h_pkg::out_t'(fout);
	endfunction

	// Bias toward zero, all ones, single set bits and single clear bits
	function automatic logic [31:0] pick_word();
		logic [31:0] w;
		case ($urandom_range(0, 9))
			0: w = 32'h0;
			1: w = 32'hFFFF_FFFF;
			2: w = 32'h1 << $urandom_range(0, 31);
			3: w = ~(32'h1 << $urandom_range(0, 31));
			default: w = $urandom;
		endcase
		return w;
	endfunction

	// Driver: launch pending items at the falling edge, hold until taken
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else if (start && !took) begin
			// hold the current item
		end else if (idle_left != 0) begin
			start <= 1'b0;
			idle_left <= idle_left - 1;
		end else if (pending_blocks.size() != 0) begin
			data <= pending_blocks.pop_front();
			start <= 1'b1;
			idle_left <= burst ? 0 : $urandom_range(0, 7);
			if ($urandom_range(0, 23) == 0)
				burst <= !burst;
		end else begin
			start <= 1'b0;
		end
	end

	// Monitor: record taken items, check each done strobe
	always @(posedge clk) begin
		took = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				took = 1'b1;
				expected_hashes.push_back(salsa_hash(data));
			end
			if (done !== 1'b0) begin
				if (expected_hashes.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTED)
						$display("%0t: result with no item pending: %h", $realtime, result);
				end else begin
					want = expected_hashes.pop_front();
					want_f = want;
					got_f = result;
					for (int k = 0; k < 8; k++) begin
						if (got_f[7-k] !== want_f[7-k]) begin
							mismatches++;
							if (mismatches <= MAX_REPORTED)
								$display("%0t: out_words_%0d_%0d expected %h actual %h",
									$realtime, 2*k, 2*k+1, want_f[7-k], got_f[7-k]);
						end
					end
				end
			end
		end
	end

	initial begin
		logic [7:0][63:0] f;
		for (int i = 0; i < 4; i++) begin
			for (int k = 0; k < 8; k++)
				case (i)
					0: f[k] = 64'h0;
					1: f[k] = '1;
					2: f[k] = 64'hAAAA_AAAA_AAAA_AAAA;
					default: f[k] = 64'h5555_5555_5555_5555;
				endcase
			pending_blocks.push_back(s20h_pkg::in_t'(f));
		end
		// one field at full scale, the rest zero
		for (int i = 0; i < 8; i++) begin
			f = '0;
			f[i] = '1;
			pending_blocks.push_back(s20h_pkg::in_t'(f));
		end
		for (int k = 0; k < 8; k++) f[k] = 64'h0000_0000_FFFF_FFFF;
		pending_blocks.push_back(s20h_pkg::in_t'(f));
		for (int k = 0; k < 8; k++) f[k] = 64'hFFFF_FFFF_0000_0000;
		pending_blocks.push_back(s20h_pkg::in_t'(f));
		for (int k = 0; k < 8; k++) f[k] = 64'h8000_0000_8000_0000;
		pending_blocks.push_back(s20h_pkg::in_t'(f));
		for (int k = 0; k < 8; k++) f[k] = 64'h0000_0001_0000_0001;
		pending_blocks.push_back(s20h_pkg::in_t'(f));
		for (int n = 0; n < NUM_RANDOM; n++) begin
			for (int k = 0; k < 8; k++)
				f[k] = (n % 2) ? {$urandom, $urandom} : {pick_word(), pick_word()};
			pending_blocks.push_back(s20h_pkg::in_t'(f));
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_blocks.size() != 0 || start)
			@(posedge clk);
		while (expected_hashes.size() != 0)
			@(posedge clk);
		// catch any stray strobe after the last result
		repeat (SETTLE) @(posedge clk);

		if (mismatches == 0 && expected_hashes.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
